// ----- rtl/mtes_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_pkg
// Shared types and constants of the MIDI track event serializer.
// ----------------------------------------------------------------------------
package mtes_pkg;

   // track store
   localparam int TRACKS      = 16;
   localparam int TRACK_W     = 4;
   localparam int TRACK_IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

   // item field widths
   localparam int TICK_W = 32;
   localparam int BYTE_W = 8;

   // variable-length quantity layout
   localparam int GROUP_W    = 7;
   localparam int VLQ_GROUPS = (TICK_W + GROUP_W - 1) / GROUP_W;
   localparam int VLQ_W      = VLQ_GROUPS * GROUP_W;
   localparam int VLQ_CNT_W  = $clog2(VLQ_GROUPS + 1);

   // fixed stream bytes
   localparam logic [BYTE_W-1:0] META_STATUS = 8'hFF;
   localparam logic [BYTE_W-1:0] EOT_TYPE    = 8'h2F;
   localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

   // item kinds
   typedef enum logic [1:0] {
      MODE_CHANNEL = 2'd0,
      MODE_META    = 2'd1,
      MODE_PAYLOAD = 2'd2,
      MODE_END     = 2'd3
   } mode_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_VLQ      = 4'b0010,
      S_BYTES    = 4'b0100,
      S_LOAD_LEN = 4'b1000
   } state_type;

   // sequencer to vlq unit
   typedef struct packed {
      logic load;
      logic advance;
   } vlq_ctrl_type;

   // vlq unit to sequencer
   typedef struct packed {
      logic              emit_now;
      logic              last_group;
      logic [BYTE_W-1:0] group;
   } vlq_stat_type;

endpackage
`default_nettype wire

// ----- rtl/mtes_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_req_if / mtes_rsp_if
// Valid/ready channels for event items and serialized stream bytes.
// ----------------------------------------------------------------------------
interface mtes_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [3:0]  track;
   logic [31:0] current_tick;
   logic [7:0]  status;
   logic [7:0]  data1;
   logic [7:0]  data2;
   logic        has_data2;
   logic [7:0]  meta_type;
   logic [31:0] payload_length;
   logic [7:0]  payload_byte;

   modport source (output valid, mode, track, current_tick, status, data1, data2,
                   has_data2, meta_type, payload_length, payload_byte,
                   input ready);
   modport sink (input valid, mode, track, current_tick, status, data1, data2,
                 has_data2, meta_type, payload_length, payload_byte,
                 output ready);
endinterface

interface mtes_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] out_track;
   logic [7:0] byte_value;
   logic       last_of_run;

   modport source (output valid, out_track, byte_value, last_of_run, input ready);
   modport sink (input valid, out_track, byte_value, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/mtes_tick_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_tick_store
// Last tick of each track, cleared at reset, with the delta subtractor.
// ----------------------------------------------------------------------------
module mtes_tick_store (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire logic [mtes_pkg::TRACK_IDX_W-1:0] idx,
   input  wire logic [mtes_pkg::TICK_W-1:0]      now,
   output      logic [mtes_pkg::TICK_W-1:0]      delta
);

   logic [mtes_pkg::TICK_W-1:0] last_ff [mtes_pkg::TRACKS];
   logic [mtes_pkg::TICK_W-1:0] last_in [mtes_pkg::TRACKS];

   // delta wraps modulo the tick width
   assign delta = now - last_ff[idx];

   // record the new tick of the addressed track
   always_comb begin
      last_in = last_ff;
      if (wr_en) begin
         last_in[idx] = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mtes_pkg::TRACKS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         last_ff <= last_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/mtes_vlq_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtes_vlq_unit
// Shared shifter that walks a value out as 7-bit groups, most significant
// first, skipping leading zero groups one step per cycle.
// ----------------------------------------------------------------------------
module mtes_vlq_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mtes_pkg::vlq_ctrl_type        ctrl,
   input  wire logic [mtes_pkg::TICK_W-1:0]   load_value,
   output      mtes_pkg::vlq_stat_type        stat
);

   logic [mtes_pkg::VLQ_W-1:0]     work_ff, work_in;
   logic [mtes_pkg::VLQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           started_ff, started_in;
   logic [mtes_pkg::GROUP_W-1:0]   top;

   // top group and its emit condition, zero groups after the first nonzero one still go out
   assign top             = work_ff[mtes_pkg::VLQ_W-1 -: mtes_pkg::GROUP_W];
   assign stat.last_group = (cnt_ff == mtes_pkg::VLQ_CNT_W'(1));
   assign stat.emit_now   = (top != '0) || stat.last_group || started_ff;
   assign stat.group      = {~stat.last_group, top};

   // load or shift one group
   always_comb begin
      work_in    = work_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      if (ctrl.load) begin
         work_in    = mtes_pkg::VLQ_W'(load_value);
         cnt_in     = mtes_pkg::VLQ_CNT_W'(mtes_pkg::VLQ_GROUPS);
         started_in = 1'b0;
      end else if (ctrl.advance) begin
         work_in    = work_ff << mtes_pkg::GROUP_W;
         cnt_in     = cnt_ff - mtes_pkg::VLQ_CNT_W'(1);
         started_in = started_ff || (top != '0);
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (reset) begin
         cnt_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/midi_track_event_serializer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// midi_track_event_serializer_core
// Turns track events into Standard MIDI File track bytes, one byte per transfer.
// ----------------------------------------------------------------------------
// Timing: an accepted item is held in the sequencer registers, and each byte is
// then registered in the output register; leading zero groups of each quantity are
// skipped first. A new item is taken only in idle, after the last byte of the
// previous one. The vlq shifter steps through every group, skipped ones included.
// Reset: synchronous; returns to idle, drops the output byte, zeroes all ticks.
// ----------------------------------------------------------------------------
module midi_track_event_serializer_core (
   input wire logic        clock,
   input wire logic        reset,
   mtes_req_if.sink        req_bus,
   mtes_rsp_if.source      rsp_bus
);

   mtes_pkg::state_type    state_ff, state_in;
   mtes_pkg::mode_type     mode_ff, mode_in, in_mode;
   logic [mtes_pkg::TRACK_W-1:0] track_ff, track_in;
   logic [mtes_pkg::BYTE_W-1:0]  status_ff, status_in;
   logic [mtes_pkg::BYTE_W-1:0]  data1_ff, data1_in;
   logic [mtes_pkg::BYTE_W-1:0]  data2_ff, data2_in;
   logic                         has2_ff, has2_in;
   logic [mtes_pkg::BYTE_W-1:0]  mtype_ff, mtype_in;
   logic [mtes_pkg::TICK_W-1:0]  plen_ff, plen_in;
   logic [mtes_pkg::BYTE_W-1:0]  pbyte_ff, pbyte_in;
   logic [1:0]                   idx_ff, idx_in;
   logic                         tail_ff, tail_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mtes_pkg::TRACK_W-1:0] rsp_track_ff, rsp_track_in;
   logic [mtes_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         accept, track_ok, out_free, stamps;
   logic                         emit, emit_last;
   logic [mtes_pkg::BYTE_W-1:0]  emit_byte, byte_sel;
   logic [1:0]                   last_idx;
   logic [mtes_pkg::TICK_W-1:0]  delta, load_value;
   logic [mtes_pkg::TRACK_IDX_W-1:0] store_idx;
   logic [31:0]                  track_wide;
   mtes_pkg::vlq_ctrl_type       vlq_ctrl;
   mtes_pkg::vlq_stat_type       vlq_stat;

   // input handshake
   assign req_bus.ready = (state_ff == mtes_pkg::S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_mode       = mtes_pkg::mode_type'(req_bus.mode);
   assign track_wide    = 32'(req_bus.track);
   assign track_ok      = (track_wide < 32'(mtes_pkg::TRACKS));
   assign store_idx     = track_wide[mtes_pkg::TRACK_IDX_W-1:0];
   assign stamps        = (in_mode == mtes_pkg::MODE_CHANNEL) ||
                          (in_mode == mtes_pkg::MODE_META);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   mtes_tick_store u_tick_store (
      .clock (clock),
      .reset (reset),
      .wr_en (accept && track_ok && stamps),
      .idx   (store_idx),
      .now   (req_bus.current_tick),
      .delta (delta)
   );

   assign load_value = (state_ff == mtes_pkg::S_LOAD_LEN) ? plen_ff : delta;

   mtes_vlq_unit u_vlq (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (vlq_ctrl),
      .load_value (load_value),
      .stat       (vlq_stat)
   );

   // fixed byte list of each kind
   always_comb begin
      byte_sel = mtes_pkg::ZERO_BYTE;
      last_idx = 2'd0;
      case (mode_ff)
         mtes_pkg::MODE_CHANNEL: begin
            last_idx = has2_ff ? 2'd2 : 2'd1;
            case (idx_ff)
               2'd0:    byte_sel = status_ff;
               2'd1:    byte_sel = data1_ff;
               default: byte_sel = data2_ff;
            endcase
         end
         mtes_pkg::MODE_META: begin
            last_idx = 2'd1;
            byte_sel = (idx_ff == 2'd0) ? mtes_pkg::META_STATUS : mtype_ff;
         end
         mtes_pkg::MODE_PAYLOAD: begin
            last_idx = 2'd0;
            byte_sel = pbyte_ff;
         end
         default: begin
            last_idx = 2'd3;
            case (idx_ff)
               2'd1:    byte_sel = mtes_pkg::META_STATUS;
               2'd2:    byte_sel = mtes_pkg::EOT_TYPE;
               default: byte_sel = mtes_pkg::ZERO_BYTE;
            endcase
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      track_in  = track_ff;
      status_in = status_ff;
      data1_in  = data1_ff;
      data2_in  = data2_ff;
      has2_in   = has2_ff;
      mtype_in  = mtype_ff;
      plen_in   = plen_ff;
      pbyte_in  = pbyte_ff;
      idx_in    = idx_ff;
      tail_in   = tail_ff;
      vlq_ctrl  = '0;
      emit      = 1'b0;
      emit_last = 1'b0;
      emit_byte = byte_sel;
      case (state_ff)
         mtes_pkg::S_IDLE: begin
            if (accept && track_ok) begin
               mode_in   = in_mode;
               track_in  = req_bus.track;
               status_in = req_bus.status;
               data1_in  = req_bus.data1;
               data2_in  = req_bus.data2;
               has2_in   = req_bus.has_data2;
               mtype_in  = req_bus.meta_type;
               plen_in   = req_bus.payload_length;
               pbyte_in  = req_bus.payload_byte;
               idx_in    = 2'd0;
               tail_in   = 1'b0;
               vlq_ctrl.load = 1'b1;
               state_in  = stamps ? mtes_pkg::S_VLQ : mtes_pkg::S_BYTES;
            end
         end
         mtes_pkg::S_VLQ: begin
            if (!vlq_stat.emit_now) begin
               // leading zero group: skip it
               vlq_ctrl.advance = 1'b1;
            end else if (out_free) begin
               vlq_ctrl.advance = 1'b1;
               emit      = 1'b1;
               emit_byte = vlq_stat.group;
               emit_last = tail_ff && vlq_stat.last_group;
               if (vlq_stat.last_group) begin
                  state_in = tail_ff ? mtes_pkg::S_IDLE : mtes_pkg::S_BYTES;
               end
            end
         end
         mtes_pkg::S_BYTES: begin
            if (out_free) begin
               emit = 1'b1;
               if (idx_ff == last_idx) begin
                  emit_last = (mode_ff != mtes_pkg::MODE_META);
                  state_in  = (mode_ff == mtes_pkg::MODE_META) ?
                              mtes_pkg::S_LOAD_LEN : mtes_pkg::S_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         mtes_pkg::S_LOAD_LEN: begin
            // payload length closes the meta header
            vlq_ctrl.load = 1'b1;
            tail_in       = 1'b1;
            state_in      = mtes_pkg::S_VLQ;
         end
         default: begin
            state_in = mtes_pkg::S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_track_in = rsp_track_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_track_in = track_ff;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_track   = rsp_track_ff;
   assign rsp_bus.byte_value  = rsp_byte_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      track_ff     <= track_in;
      status_ff    <= status_in;
      data1_ff     <= data1_in;
      data2_ff     <= data2_in;
      has2_ff      <= has2_in;
      mtype_ff     <= mtype_in;
      plen_ff      <= plen_in;
      pbyte_ff     <= pbyte_in;
      idx_ff       <= idx_in;
      tail_ff      <= tail_in;
      rsp_track_ff <= rsp_track_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= mtes_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
